/* hw/rtl/crc16_packet_receiver_defines.svh */
// Assertion macros shared by the packet receiver checker.
`ifndef CRC16_PACKET_RECEIVER_DEFINES_SVH
`define CRC16_PACKET_RECEIVER_DEFINES_SVH

// General property check, sampled on the rising clock and disabled in reset.
`define CPR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A beat offered but not taken must stay offered with the same payload.
`define CPR_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error(msg);

`endif

/* hw/rtl/cpr_pkg.sv */
// Types, constants and the CRC step function of the packet receiver.
package cpr_pkg;

  localparam int BufDepth  = 32;
  localparam int AddrW     = $clog2(BufDepth);
  localparam int ByteW     = 8;
  localparam int IdW       = 16;
  localparam int CrcW      = 16;
  localparam int LenW      = 5;
  localparam int CmdQDepth = 2;
  localparam int QPtrW     = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int QCntW     = $clog2(CmdQDepth + 1);

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdW-1:0]   id_t;
  typedef logic [CrcW-1:0]  crc_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [AddrW-1:0] addr_t;

  // Parser position within a frame.
  typedef enum logic [2:0] {
    PH_ID_HI  = 3'd0,
    PH_ID_LO  = 3'd1,
    PH_LEN    = 3'd2,
    PH_CHECK  = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_e;

  // Replay sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FETCH = 2'd1,
    BK_SEND  = 2'd2
  } back_state_e;

  // Commands passed from the parser to the replay side.
  typedef enum logic [1:0] {
    CMD_STORE  = 2'd0,
    CMD_ACK    = 2'd1,
    CMD_NAK    = 2'd2,
    CMD_REPLAY = 2'd3
  } cmd_e;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACK    = 2'd1,
    EV_NAK    = 2'd2,
    EV_PACKET = 2'd3
  } event_e;

  typedef struct packed {
    cmd_e  kind;
    id_t   id;
    len_t  len;
    crc_t  crc;
    byte_t data;
    addr_t idx;
  } cmd_t;

  typedef struct packed {
    event_e    event_res;
    id_t       packet_id;
    len_t      packet_length;
    logic      data_valid;
    byte_t     data_byte;
    len_t      data_index;
    crc_t      crc_value;
    logic      last;
  } res_t;

  // One byte of CRC-16/CCITT, MSB first.
  function automatic crc_t crc_update(crc_t crc, byte_t b);
    crc_t c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/cpr_rx_if.sv */
// Receive byte channel: valid, ready and one serial byte.
interface cpr_rx_if;
  logic            valid;
  logic            ready;
  cpr_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/cpr_res_if.sv */
// Result channel: valid, ready and the fields of one result.
interface cpr_res_if;
  logic            valid;
  logic            ready;
  logic [1:0]      event_res;
  cpr_pkg::id_t    packet_id;
  cpr_pkg::len_t   packet_length;
  logic            data_valid;
  cpr_pkg::byte_t  data_byte;
  cpr_pkg::len_t   data_index;
  cpr_pkg::crc_t   crc_value;
  logic            last;

  modport source (output valid, output event_res, output packet_id, output packet_length,
                  output data_valid, output data_byte, output data_index,
                  output crc_value, output last, input ready);
  modport sink   (input valid, input event_res, input packet_id, input packet_length,
                  input data_valid, input data_byte, input data_index,
                  input crc_value, input last, output ready);
endinterface

/* hw/rtl/crc16_packet_receiver.sv */
// Framed packet receiver with CRC-16/CCITT check. Bytes enter on rx_i, one beat
// per cycle while the two-entry command queue has room; header, id, length and CRC
// bytes are parsed each in its own phase, and every data byte, header verdict and
// CRC verdict becomes a queued command. The replay side drains that queue: a data
// byte is stored, an acknowledge or negative acknowledge gives one result beat, and
// an accepted packet of n data bytes gives n result beats, each one passing the
// registered read of the 32-byte data store followed by the output register, and
// no further command is taken until its last beat. An empty packet gives a single
// acceptance beat. After reset the block is ready at once; the data store needs no
// clearing since only bytes of the current frame are replayed.
module crc16_packet_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpr_rx_if.sink     rx_i,
  cpr_res_if.source  res_o
);
  import cpr_pkg::*;

  logic fifo_full;
  logic fifo_empty;
  logic push;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_out;

  // Parser front.
  cpr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .full_i (fifo_full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // Queue between parser and replay side.
  cpr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (fifo_empty)
  );

  // Replay back end.
  cpr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_out),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

/* hw/rtl/cpr_cmd_fifo.sv */
// Short command queue between the frame parser and the replay side.
module cpr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cpr_pkg::cmd_t data_o,
  output logic          empty_o
);
  import cpr_pkg::*;

  cmd_t             entry_q [CmdQDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(CmdQDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/cpr_front.sv */
// Frame parser: takes received bytes, checks header and CRC, issues commands.
module cpr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpr_rx_if.sink        rx_i,
  input  logic          full_i,
  output logic          push_o,
  output cpr_pkg::cmd_t cmd_o
);
  import cpr_pkg::*;

  phase_e phase_q, phase_d;
  id_t    id_q, id_d;
  len_t   len_q, len_d;
  len_t   cnt_q, cnt_d;
  crc_t   crc_q, crc_d;
  logic   hi_ok_q, hi_ok_d;

  logic   accept;
  byte_t  b;
  byte_t  hdr_chk;
  logic   hdr_ok;
  len_t   cnt_inc;
  logic   crc_ok;

  // Every byte may produce one command, so take bytes only while the queue has room.
  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && !full_i;
  assign b          = rx_i.rx_byte;
  assign hdr_chk    = byte_t'(len_q) ^ id_q[IdW-1:ByteW] ^ id_q[ByteW-1:0];
  assign hdr_ok     = (b == hdr_chk);
  assign cnt_inc    = cnt_q + LenW'(1);
  assign crc_ok     = hi_ok_q && (crc_q[ByteW-1:0] == b);

  // Next parser phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_ID_LO:  phase_d = PH_LEN;
        PH_LEN:    phase_d = PH_CHECK;
        PH_CHECK: begin
          if (!hdr_ok) begin
            phase_d = PH_ID_HI;
          end else if (len_q == '0) begin
            phase_d = PH_CRC_HI;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if ((cnt_inc == '0) || (cnt_inc >= len_q)) begin
            phase_d = PH_CRC_HI;
          end
        end
        PH_CRC_HI: phase_d = PH_CRC_LO;
        PH_CRC_LO: phase_d = PH_ID_HI;
        // The id high byte; the unused code behaves the same.
        default:   phase_d = PH_ID_LO;
      endcase
    end
  end

  // Frame registers and the command for the queue.
  always_comb begin
    id_d         = id_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    hi_ok_d      = hi_ok_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    cmd_o.kind   = CMD_STORE;
    cmd_o.id     = id_q;
    cmd_o.len    = len_q;
    cmd_o.crc    = crc_q;
    cmd_o.data   = b;
    cmd_o.idx    = addr_t'(cnt_q);
    if (accept) begin
      unique case (phase_q)
        PH_ID_LO:  id_d  = {id_q[IdW-1:ByteW], b};
        PH_LEN:    len_d = b[LenW-1:0];
        PH_CHECK: begin
          push_o     = 1'b1;
          cmd_o.kind = hdr_ok ? CMD_ACK : CMD_NAK;
        end
        PH_DATA: begin
          push_o = 1'b1;
          crc_d  = crc_update(crc_q, b);
          cnt_d  = cnt_inc;
        end
        PH_CRC_HI: hi_ok_d = (crc_q[CrcW-1:ByteW] == b);
        PH_CRC_LO: begin
          push_o     = 1'b1;
          cmd_o.kind = crc_ok ? CMD_REPLAY : CMD_NAK;
        end
        default:   id_d = {b, {ByteW{1'b0}}};
      endcase
      // Restart on any header rejection or at the end of the CRC.
      if ((phase_q == PH_CRC_LO) || ((phase_q == PH_CHECK) && !hdr_ok)) begin
        cnt_d   = '0;
        crc_d   = CrcInit;
        hi_ok_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID_HI;
      id_q    <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= CrcInit;
      hi_ok_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      hi_ok_q <= hi_ok_d;
    end
  end

endmodule

/* hw/rtl/cpr_back.sv */
// Replay side: stores data bytes, emits events and replays accepted packets.
module cpr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpr_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  cpr_res_if.source     res_o
);
  import cpr_pkg::*;

  back_state_e state_q, state_d;
  len_t        idx_q, idx_d;
  id_t         rep_id_q, rep_id_d;
  len_t        rep_len_q, rep_len_d;
  crc_t        rep_crc_q, rep_crc_d;
  byte_t       mem [BufDepth];
  byte_t       rd_data_q;
  res_t        res_q, res_d;
  logic        out_valid_q, out_valid_d;

  logic        slot_free;
  logic        has_cmd;
  logic        is_burst;
  logic        at_last;
  logic        mem_we;
  logic        load_out;

  assign slot_free = !out_valid_q || res_o.ready;
  assign has_cmd   = !empty_i;
  assign is_burst  = (cmd_i.kind == CMD_REPLAY) && (cmd_i.len != '0);
  assign at_last   = (idx_q == rep_len_q - LenW'(1));

  // Next sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (has_cmd && is_burst) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: state_d = BK_SEND;
      BK_SEND: begin
        if (slot_free) begin
          state_d = at_last ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Queue pops, store writes and the next result.
  always_comb begin
    pop_o               = 1'b0;
    mem_we              = 1'b0;
    load_out            = 1'b0;
    idx_d               = idx_q;
    rep_id_d            = rep_id_q;
    rep_len_d           = rep_len_q;
    rep_crc_d           = rep_crc_q;
    res_d               = '0;
    res_d.event_res     = EV_NONE;
    res_d.last          = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        if (has_cmd) begin
          unique case (cmd_i.kind)
            CMD_STORE: begin
              pop_o  = 1'b1;
              mem_we = 1'b1;
            end
            CMD_ACK, CMD_NAK: begin
              pop_o           = slot_free;
              load_out        = slot_free;
              res_d.event_res = (cmd_i.kind == CMD_ACK) ? EV_ACK : EV_NAK;
            end
            default: begin
              if (is_burst) begin
                pop_o     = 1'b1;
                idx_d     = '0;
                rep_id_d  = cmd_i.id;
                rep_len_d = cmd_i.len;
                rep_crc_d = cmd_i.crc;
              end else begin
                // Empty packet: one acceptance with no data byte.
                pop_o           = slot_free;
                load_out        = slot_free;
                res_d.event_res = EV_PACKET;
                res_d.packet_id = cmd_i.id;
                res_d.crc_value = cmd_i.crc;
              end
            end
          endcase
        end
      end
      BK_SEND: begin
        load_out            = slot_free;
        res_d.event_res     = EV_PACKET;
        res_d.packet_id     = rep_id_q;
        res_d.packet_length = rep_len_q;
        res_d.data_valid    = 1'b1;
        res_d.data_byte     = rd_data_q;
        res_d.data_index    = idx_q;
        res_d.crc_value     = rep_crc_q;
        res_d.last          = at_last;
        if (slot_free && !at_last) begin
          idx_d = idx_q + LenW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // The output register holds a beat until it is taken.
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rep_id_q  <= rep_id_d;
    rep_len_q <= rep_len_d;
    rep_crc_q <= rep_crc_d;
    if (load_out) begin
      res_q <= res_d;
    end
  end

  // Data store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.idx] <= cmd_i.data;
    end
    rd_data_q <= mem[addr_t'(idx_q)];
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.event_res     = res_q.event_res;
  assign res_o.packet_id     = res_q.packet_id;
  assign res_o.packet_length = res_q.packet_length;
  assign res_o.data_valid    = res_q.data_valid;
  assign res_o.data_byte     = res_q.data_byte;
  assign res_o.data_index    = res_q.data_index;
  assign res_o.crc_value     = res_q.crc_value;
  assign res_o.last          = res_q.last;

endmodule

/* hw/rtl/cpr_checker.sv */
// Port-level checks of the packet receiver results, bound to the top level.
`include "crc16_packet_receiver_defines.svh"

module cpr_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [1:0]          event_res_i,
  input  cpr_pkg::id_t        packet_id_i,
  input  cpr_pkg::len_t       packet_length_i,
  input  logic                data_valid_i,
  input  cpr_pkg::len_t       data_index_i,
  input  logic                last_i
);
  import cpr_pkg::*;

  // A stalled result beat keeps its event.
  `CPR_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, res_valid_i, res_ready_i, event_res_i, "result beat changed while stalled")

  // A data beat belongs to an accepted packet and lies inside it; last marks its end.
  `CPR_ASSERT(a_data_in_packet, clk_i, rst_ni, (res_valid_i && data_valid_i) |-> ((event_res_i == EV_PACKET) && (data_index_i < packet_length_i) && (last_i == (data_index_i == packet_length_i - 5'd1))), "data beat outside its packet")

  // Header verdicts are single beats with no packet fields.
  `CPR_ASSERT(a_verdict_single, clk_i, rst_ni, (res_valid_i && ((event_res_i == EV_ACK) || (event_res_i == EV_NAK))) |-> (last_i && !data_valid_i && (packet_id_i == '0) && (packet_length_i == '0)), "verdict beat malformed")

  // An acceptance without data is an empty packet in one beat.
  `CPR_ASSERT(a_empty_packet, clk_i, rst_ni, (res_valid_i && (event_res_i == EV_PACKET) && !data_valid_i) |-> (last_i && (packet_length_i == '0)), "empty packet beat malformed")

endmodule

bind crc16_packet_receiver cpr_checker u_cpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .event_res_i     (res_o.event_res),
  .packet_id_i     (res_o.packet_id),
  .packet_length_i (res_o.packet_length),
  .data_valid_i    (res_o.data_valid),
  .data_index_i    (res_o.data_index),
  .last_i          (res_o.last)
);
